>>> src/lcb_pkg.sv
// Shared constants for the bouncing LED chase segment generator.
package lcb_pkg;

  // Strip geometry and crossfade resolution
  localparam int unsigned STRIP_LEN  = 64;
  localparam int unsigned FADE_STEPS = 240;

  // floor(x / 15) for x < 4096 as (x * RECIP_15) >> RECIP_SHIFT
  localparam logic [11:0] RECIP_15    = 12'd2185;
  localparam int unsigned RECIP_SHIFT = 15;

  // Request kinds carried in tuser
  localparam logic [1:0] REQ_TICK    = 2'd0;
  localparam logic [1:0] REQ_PIXEL   = 2'd1;
  localparam logic [1:0] REQ_RESTART = 2'd2;

  // Configuration register indexes (byte address = 4 * index)
  localparam logic [2:0] REG_COLOR_RED      = 3'd0;
  localparam logic [2:0] REG_COLOR_GREEN    = 3'd1;
  localparam logic [2:0] REG_COLOR_BLUE     = 3'd2;
  localparam logic [2:0] REG_COLOR_ALPHA    = 3'd3;
  localparam logic [2:0] REG_START_POSITION = 3'd4;
  localparam logic [2:0] REG_START_REVERSE  = 3'd5;
  localparam logic [2:0] REG_RUN_WIDTH      = 3'd6;

  localparam int unsigned PADDR_W = 5;

endpackage

>>> src/led_chase_bounce_generator_core.sv
// Bouncing LED chase segment generator: tick, pixel query and restart processing.
// Pipeline: a pixel query result reaches the master side through the input register, then
// the result register. Throughput: one beat per cycle while no pixel query waits on a held
// result; tick and restart beats update state, no output beat.
// Reset (rst_ni low, asynchronous): configuration to its reset values, head at 0,
// moving down, both end alphas zero, both pipeline registers empty.
module led_chase_bounce_generator_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // Request stream
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [15:0]                 s_axis_tdata,  // [7:0] beat_fraction, [15:8] pixel_position
  input  logic [1:0]                  s_axis_tuser,  // [1:0] req_type
  // Pixel result stream
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [31:0]                 m_axis_tdata,  // [7:0] red, [15:8] green,
                                                     // [23:16] blue, [31:24] alpha
  // Configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lcb_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [7:0] color_red_q, color_green_q, color_blue_q, color_alpha_q;
  logic [7:0] start_position_q;
  logic       start_reverse_q;
  logic [6:0] run_width_q;
  logic       cfg_wr;
  logic [2:0] cfg_idx;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[4:2];
  assign cfg_wr  = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      color_red_q      <= '0;
      color_green_q    <= '0;
      color_blue_q     <= '0;
      color_alpha_q    <= '0;
      start_position_q <= '0;
      start_reverse_q  <= 1'b1;
      run_width_q      <= 7'd4;
    end else if (cfg_wr) begin
      case (cfg_idx)
        lcb_pkg::REG_COLOR_RED:      color_red_q      <= pwdata[7:0];
        lcb_pkg::REG_COLOR_GREEN:    color_green_q    <= pwdata[7:0];
        lcb_pkg::REG_COLOR_BLUE:     color_blue_q     <= pwdata[7:0];
        lcb_pkg::REG_COLOR_ALPHA:    color_alpha_q    <= pwdata[7:0];
        lcb_pkg::REG_START_POSITION: start_position_q <= pwdata[7:0];
        lcb_pkg::REG_START_REVERSE:  start_reverse_q  <= pwdata[0];
        lcb_pkg::REG_RUN_WIDTH:      run_width_q      <= pwdata[6:0];
        default: ;  // unmapped address: drop the write
      endcase
    end
  end

  // Read back the addressed register, zero for unmapped addresses
  always_comb begin
    prdata = '0;
    case (cfg_idx)
      lcb_pkg::REG_COLOR_RED:      prdata[7:0] = color_red_q;
      lcb_pkg::REG_COLOR_GREEN:    prdata[7:0] = color_green_q;
      lcb_pkg::REG_COLOR_BLUE:     prdata[7:0] = color_blue_q;
      lcb_pkg::REG_COLOR_ALPHA:    prdata[7:0] = color_alpha_q;
      lcb_pkg::REG_START_POSITION: prdata[7:0] = start_position_q;
      lcb_pkg::REG_START_REVERSE:  prdata[0]   = start_reverse_q;
      lcb_pkg::REG_RUN_WIDTH:      prdata[6:0] = run_width_q;
      default:                     prdata      = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Input register: capture the beat and form alpha * fraction up front so the
  // processing cycle only has the constant divide left.
  // ---------------------------------------------------------------------------
  logic        in_valid_q;
  logic [1:0]  in_kind_q;
  logic        in_frac_zero_q;
  logic        in_sat_q;
  logic [7:0]  in_pos_q;
  logic [15:0] in_prod_q;
  logic        s_accept;
  logic        advance;
  logic        out_free;

  assign out_free      = !m_axis_tvalid || m_axis_tready;
  // Non-pixel beats never touch the result register, so only a pixel query
  // waits for it.
  assign advance       = in_valid_q && ((in_kind_q != lcb_pkg::REQ_PIXEL) || out_free);
  assign s_axis_tready = !in_valid_q || advance;
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_accept) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      in_kind_q      <= s_axis_tuser;
      in_frac_zero_q <= (s_axis_tdata[7:0] == 8'd0);
      in_sat_q       <= ({8'd0, s_axis_tdata[7:0]} >= 16'(lcb_pkg::FADE_STEPS));
      in_pos_q       <= s_axis_tdata[15:8];
      in_prod_q      <= 16'(color_alpha_q) * 16'(s_axis_tdata[7:0]);
    end
  end

  // ---------------------------------------------------------------------------
  // Segment state
  // ---------------------------------------------------------------------------
  logic [7:0] head_q, head_d;
  logic       rev_q, rev_d;
  logic [7:0] head_alpha_q, head_alpha_d;
  logic [7:0] tail_alpha_q, tail_alpha_d;

  // Crossfade amount: floor(prod / 240) = floor(floor(prod / 16) / 15)
  logic [11:0] prod_div16;
  logic [23:0] recip_prod;
  logic [7:0]  fade;
  logic        flip;
  logic        rev_move;
  logic [8:0]  head_plus_width;

  assign prod_div16 = in_prod_q[15:4];
  assign recip_prod = 24'(prod_div16) * 24'(lcb_pkg::RECIP_15);
  assign fade       = in_sat_q ? color_alpha_q : recip_prod[lcb_pkg::RECIP_SHIFT +: 8];

  // Tail end without wrap: a tail past 255 never lights
  assign head_plus_width = {1'b0, head_q} + {2'b00, run_width_q};
  assign flip = (head_q == 8'd0) || (head_plus_width >= 9'(lcb_pkg::STRIP_LEN));
  assign rev_move = in_frac_zero_q ? (rev_q ^ flip) : rev_q;

  always_comb begin
    head_d       = head_q;
    rev_d        = rev_q;
    head_alpha_d = head_alpha_q;
    tail_alpha_d = tail_alpha_q;
    if (advance) begin
      case (in_kind_q)
        lcb_pkg::REQ_TICK: begin
          // Bounce and step on the beat, then crossfade the two end pixels
          rev_d = rev_move;
          if (in_frac_zero_q) begin
            head_d = rev_move ? (head_q - 8'd1) : (head_q + 8'd1);
          end
          if (rev_move) begin
            head_alpha_d = fade;
            tail_alpha_d = color_alpha_q - fade;
          end else begin
            tail_alpha_d = fade;
            head_alpha_d = color_alpha_q - fade;
          end
        end
        lcb_pkg::REQ_RESTART: begin
          head_d       = start_position_q;
          rev_d        = start_reverse_q;
          head_alpha_d = '0;
          tail_alpha_d = '0;
        end
        default: ;  // pixel queries read state only; unknown kinds are dropped
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q       <= '0;
      rev_q        <= 1'b1;
      head_alpha_q <= '0;
      tail_alpha_q <= '0;
    end else begin
      head_q       <= head_d;
      rev_q        <= rev_d;
      head_alpha_q <= head_alpha_d;
      tail_alpha_q <= tail_alpha_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Pixel lookup and result register
  // ---------------------------------------------------------------------------
  logic [8:0]  pos_ext;
  logic [31:0] pix_rgba;
  logic        out_load;

  assign pos_ext  = {1'b0, in_pos_q};
  assign out_load = advance && (in_kind_q == lcb_pkg::REQ_PIXEL);

  // Head test wins, then strictly inside, then the tail end
  always_comb begin
    if (in_pos_q == head_q) begin
      pix_rgba = {head_alpha_q, color_blue_q, color_green_q, color_red_q};
    end else if ((in_pos_q > head_q) && (pos_ext < head_plus_width)) begin
      pix_rgba = {color_alpha_q, color_blue_q, color_green_q, color_red_q};
    end else if (pos_ext == head_plus_width) begin
      pix_rgba = {tail_alpha_q, color_blue_q, color_green_q, color_red_q};
    end else begin
      pix_rgba = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      m_axis_tdata <= pix_rgba;
    end
  end

endmodule

>>> bench/testbench.sv
// Self-checking bench for the bouncing LED chase segment generator core.
`timescale 1ns / 1ps

module testbench;

  // Request kind the core ignores
  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned PHASES = 8;
  localparam int unsigned ITEMS_PER_PHASE = 140;

  // One result beat, alpha in the top byte
  typedef struct packed {
    logic [7:0] alpha;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } pixel_t;

  // Track the segment state and queue the pixel each query must return
  class chase_scoreboard;
    logic [7:0] color_red, color_green, color_blue, color_alpha, start_position;
    logic       start_reverse;
    logic [6:0] run_width;
    logic [7:0] head;
    logic       reverse;
    logic [7:0] head_alpha, tail_alpha;
    pixel_t     expected_pixels[$];
    int unsigned error_count;

    function new();
      color_red = '0;
      color_green = '0;
      color_blue = '0;
      color_alpha = '0;
      start_position = '0;
      start_reverse = 1'b1;
      run_width = 7'd4;
      head = '0;
      reverse = 1'b1;
      head_alpha = '0;
      tail_alpha = '0;
      error_count = 0;
    endfunction

    function void set_register(logic [2:0] idx, logic [7:0] value);
      case (idx)
        lcb_pkg::REG_COLOR_RED:      color_red = value;
        lcb_pkg::REG_COLOR_GREEN:    color_green = value;
        lcb_pkg::REG_COLOR_BLUE:     color_blue = value;
        lcb_pkg::REG_COLOR_ALPHA:    color_alpha = value;
        lcb_pkg::REG_START_POSITION: start_position = value;
        lcb_pkg::REG_START_REVERSE:  start_reverse = value[0];
        lcb_pkg::REG_RUN_WIDTH:      run_width = value[6:0];
        default: ;
      endcase
    endfunction

    // Apply one accepted request beat to the predicted state
    function void note_request(logic [1:0] kind, logic [7:0] frac, logic [7:0] pos);
      int unsigned fade;
      int unsigned tail_end;
      pixel_t px;
      case (kind)
        lcb_pkg::REQ_TICK: begin
          if (frac == 8'd0) begin
            // Bounce off either end before stepping
            if (head == 8'd0 || (int'(head) + int'(run_width)) >= lcb_pkg::STRIP_LEN)
              reverse = ~reverse;
            head = reverse ? head - 8'd1 : head + 8'd1;
          end
          // Saturate the fade for fractions past the end of the beat
          if (frac >= lcb_pkg::FADE_STEPS) fade = 32'(color_alpha);
          else fade = (int'(color_alpha) * int'(frac)) / lcb_pkg::FADE_STEPS;
          if (reverse) begin
            head_alpha = fade[7:0];
            tail_alpha = color_alpha - fade[7:0];
          end else begin
            tail_alpha = fade[7:0];
            head_alpha = color_alpha - fade[7:0];
          end
        end
        lcb_pkg::REQ_RESTART: begin
          head = start_position;
          reverse = start_reverse;
          head_alpha = '0;
          tail_alpha = '0;
        end
        lcb_pkg::REQ_PIXEL: begin
          // Tail end does not wrap, so a tail past 255 never lights
          tail_end = int'(head) + int'(run_width);
          px.red = color_red;
          px.green = color_green;
          px.blue = color_blue;
          if (pos == head) px.alpha = head_alpha;
          else if (pos > head && pos < tail_end) px.alpha = color_alpha;
          else if (pos == tail_end) px.alpha = tail_alpha;
          else px = '0;
          expected_pixels.push_back(px);
        end
        default: ;
      endcase
    endfunction

    task report(string msg);
      if (error_count < 50) $display("MISMATCH at %0t: %s", $time, msg);
      error_count++;
    endtask

    task check_pixel(logic [31:0] data);
      pixel_t got;
      pixel_t exp_px;
      got = pixel_t'(data);
      if (expected_pixels.size() == 0) begin
        report($sformatf("pixel beat %h with nothing expected", data));
      end else begin
        exp_px = expected_pixels.pop_front();
        if (got.red !== exp_px.red)
          report($sformatf("red %h, expected %h", got.red, exp_px.red));
        if (got.green !== exp_px.green)
          report($sformatf("green %h, expected %h", got.green, exp_px.green));
        if (got.blue !== exp_px.blue)
          report($sformatf("blue %h, expected %h", got.blue, exp_px.blue));
        if (got.alpha !== exp_px.alpha)
          report($sformatf("alpha %h, expected %h", got.alpha, exp_px.alpha));
      end
    endtask
  endclass

  logic                        clk_i;
  logic                        rst_ni;
  logic                        s_axis_tvalid;
  logic                        s_axis_tready;
  logic [15:0]                 s_axis_tdata;   // [7:0] beat_fraction, [15:8] pixel_position
  logic [1:0]                  s_axis_tuser;   // [1:0] req_type
  logic                        m_axis_tvalid;
  logic                        m_axis_tready;
  logic [31:0]                 m_axis_tdata;   // [7:0] red, [15:8] green, [23:16] blue,
                                               // [31:24] alpha
  logic                        psel;
  logic                        penable;
  logic                        pwrite;
  logic [lcb_pkg::PADDR_W-1:0] paddr;
  logic [31:0]                 pwdata;
  logic [31:0]                 prdata;
  logic                        pready;

  chase_scoreboard sb;
  int unsigned     cycle_count;
  logic            hold_off_req;

  led_chase_bounce_generator_core uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Give up well past the slowest legal run
  initial cycle_count = 0;
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  // Sample both handshakes at the rising edge, inputs are stable here
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) sb.check_pixel(m_axis_tdata);
      if (s_axis_tvalid && s_axis_tready)
        sb.note_request(s_axis_tuser, s_axis_tdata[7:0], s_axis_tdata[15:8]);
    end
  end

  // Receiver: stall on a changing pattern, or hold off for a long stretch on request
  initial begin : receiver
    int unsigned stall_mode;
    int unsigned run_left;
    int unsigned tick_count;
    m_axis_tready = 1'b0;
    stall_mode = 0;
    run_left = 20;
    tick_count = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_off_req) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_off_req = 1'b0;
      end else begin
        tick_count++;
        case (stall_mode)
          0: m_axis_tready <= 1'b1;
          1: m_axis_tready <= ($urandom_range(0, 3) != 0);
          2: m_axis_tready <= (tick_count % 5 >= 2);
          default: m_axis_tready <= ($urandom_range(0, 3) == 0);
        endcase
        run_left--;
        if (run_left == 0) begin
          stall_mode = $urandom_range(0, 3);
          run_left = $urandom_range(10, 60);
        end
      end
    end
  end

  // Offer one request beat and hold it until accepted; return at a falling edge
  task send_request(logic [1:0] kind, logic [7:0] frac, logic [7:0] pos);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= kind;
    s_axis_tdata <= {pos, frac};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task pause_sender(int unsigned cycles);
    s_axis_tvalid <= 1'b0;
    repeat (cycles) @(negedge clk_i);
  endtask

  // Drop valid, wait for every pending pixel and let the pipeline empty
  task wait_idle();
    s_axis_tvalid <= 1'b0;
    while (sb.expected_pixels.size() != 0) @(negedge clk_i);
    repeat (6) @(negedge clk_i);
  endtask

  task write_reg(logic [2:0] idx, logic [7:0] value);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= {24'd0, value};
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    sb.set_register(idx, value);
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task configure(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic [7:0] a,
                 logic [7:0] start_pos, logic start_rev, logic [6:0] width);
    write_reg(lcb_pkg::REG_COLOR_RED, r);
    write_reg(lcb_pkg::REG_COLOR_GREEN, g);
    write_reg(lcb_pkg::REG_COLOR_BLUE, b);
    write_reg(lcb_pkg::REG_COLOR_ALPHA, a);
    write_reg(lcb_pkg::REG_START_POSITION, start_pos);
    write_reg(lcb_pkg::REG_START_REVERSE, {7'd0, start_rev});
    write_reg(lcb_pkg::REG_RUN_WIDTH, {1'b0, width});
    @(negedge clk_i);
  endtask

  // Mostly ticks and queries near the segment, some restarts and ignored kinds
  task random_requests(int unsigned count, bit no_gaps);
    int unsigned burst;
    int unsigned pick;
    logic [7:0]  frac;
    logic [7:0]  pos;
    burst = $urandom_range(1, 24);
    for (int unsigned i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        case ($urandom_range(0, 19))
          0, 1, 2, 3, 4: frac = 8'd0;
          5:             frac = 8'($urandom_range(240, 255));
          default:       frac = 8'($urandom_range(1, 239));
        endcase
        send_request(lcb_pkg::REQ_TICK, frac, 8'($urandom_range(0, 255)));
      end else if (pick < 88) begin
        if ($urandom_range(0, 9) < 7)
          pos = 8'(int'(sb.head) + int'($urandom_range(0, int'(sb.run_width) + 2)) - 1);
        else
          pos = 8'($urandom_range(0, 255));
        send_request(lcb_pkg::REQ_PIXEL, 8'($urandom_range(0, 255)), pos);
      end else if (pick < 94) begin
        send_request(lcb_pkg::REQ_RESTART, 8'($urandom_range(0, 255)),
                     8'($urandom_range(0, 255)));
      end else begin
        send_request(REQ_UNUSED, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      end
      burst--;
      if (burst == 0) begin
        // Leave some bursts back to back
        if (!no_gaps && $urandom_range(0, 3) != 0) pause_sender($urandom_range(1, 8));
        burst = $urandom_range(1, 24);
      end
    end
  endtask

  initial begin : stimulus
    sb = new();
    hold_off_req = 1'b0;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = lcb_pkg::REQ_TICK;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: segment at 10..14 moving up, full alpha so fades are visible
    configure(8'hff, 8'h00, 8'h81, 8'hff, 8'd10, 1'b0, 7'd4);
    send_request(lcb_pkg::REQ_RESTART, 8'd0, 8'd0);
    send_request(lcb_pkg::REQ_PIXEL, 8'd0, 8'd10);     // head with cleared alpha
    send_request(lcb_pkg::REQ_PIXEL, 8'd0, 8'd11);     // inside
    send_request(lcb_pkg::REQ_PIXEL, 8'd0, 8'd14);     // tail
    send_request(lcb_pkg::REQ_PIXEL, 8'd0, 8'd15);     // past the tail
    send_request(lcb_pkg::REQ_PIXEL, 8'd0, 8'd9);      // behind the head
    send_request(lcb_pkg::REQ_PIXEL, 8'hff, 8'd0);
    send_request(lcb_pkg::REQ_PIXEL, 8'd0, 8'd255);
    send_request(lcb_pkg::REQ_TICK, 8'd0, 8'hff);      // step to 11
    send_request(lcb_pkg::REQ_TICK, 8'd239, 8'd0);
    send_request(lcb_pkg::REQ_PIXEL, 8'd0, 8'd11);
    send_request(lcb_pkg::REQ_PIXEL, 8'd0, 8'd15);
    send_request(lcb_pkg::REQ_TICK, 8'd120, 8'd0);
    send_request(lcb_pkg::REQ_PIXEL, 8'd0, 8'd15);
    send_request(lcb_pkg::REQ_TICK, 8'd240, 8'd0);     // fade saturates
    send_request(lcb_pkg::REQ_PIXEL, 8'd0, 8'd11);
    send_request(lcb_pkg::REQ_TICK, 8'd255, 8'd0);
    send_request(lcb_pkg::REQ_PIXEL, 8'd0, 8'd15);
    send_request(REQ_UNUSED, 8'd0, 8'd11);             // ignored kind, no move
    send_request(lcb_pkg::REQ_PIXEL, 8'd0, 8'd11);
    send_request(lcb_pkg::REQ_RESTART, 8'd0, 8'd0);
    send_request(lcb_pkg::REQ_TICK, 8'd1, 8'd0);
    send_request(lcb_pkg::REQ_PIXEL, 8'd0, 8'd10);
    wait_idle();

    for (int unsigned phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: configure(8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 1'b1, 7'd127);
        1: configure(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 7'd0);
        2: configure(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                     8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                     8'($urandom_range(0, 63)), 1'($urandom_range(0, 1)), 7'd0);
        3: configure(8'h5a, 8'ha5, 8'h3c, 8'hf0, 8'd60, 1'b0, 7'd3);
        default: configure(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                           8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                           8'(($urandom_range(0, 9) < 7) ? $urandom_range(0, 70)
                                                         : $urandom_range(0, 255)),
                           1'($urandom_range(0, 1)),
                           7'(($urandom_range(0, 9) < 7) ? $urandom_range(0, 12)
                                                         : $urandom_range(0, 127)));
      endcase
      send_request(lcb_pkg::REQ_RESTART, 8'd0, 8'd0);
      // Hold the receiver off once while the sender keeps pushing
      if (phase == 3) hold_off_req = 1'b1;
      random_requests(ITEMS_PER_PHASE, phase == 3 || phase == 6);
      wait_idle();
    end

    if (sb.expected_pixels.size() != 0)
      sb.report($sformatf("%0d pixel beats never arrived", sb.expected_pixels.size()));
    if (sb.error_count == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
src/lcb_pkg.sv
src/led_chase_bounce_generator_core.sv
bench/testbench.sv
